FILE: sv/sql_transaction_keyword_classifier_assert.svh
// assertion macros for the sql transaction keyword classifier
`ifndef SQL_TRANSACTION_KEYWORD_CLASSIFIER_ASSERT_SVH
`define SQL_TRANSACTION_KEYWORD_CLASSIFIER_ASSERT_SVH

// property checked outside reset
`define STKC_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define STKC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/stkc_pkg.sv
// types and constants shared by the keyword classifier modules
`timescale 1ns / 1ps
`default_nettype none
package stkc_pkg;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_DASH,
		PH_LINE,
		PH_SLASH,
		PH_BLOCK,
		PH_BLOCK_STAR,
		PH_WORD,
		PH_DONE
	} scan_phase_t;

	typedef enum logic [2:0] {
		CC_WS,
		CC_EOL,
		CC_DASH,
		CC_SLASH,
		CC_STAR,
		CC_LETTER,
		CC_OTHER
	} char_class_t;

	typedef enum logic [2:0] {
		KW_NONE,
		KW_BEGIN,
		KW_START,
		KW_COMMIT,
		KW_END,
		KW_ROLLBACK,
		KW_ABORT
	} kw_code_t;

	typedef struct packed {
		char_class_t cls;
		logic [7:0]  ch;
		logic        last;
	} cls_item_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam int KW_COUNT    = 6;
	localparam int KW_TEXT_LEN = 8;

	// right-aligned text, first letter in the highest used byte
	localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		64'("begin"), 64'("start"), 64'("commit"),
		64'("end"), 64'("rollback"), 64'("abort")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd5, 4'd5, 4'd6, 4'd3, 4'd8, 4'd5};

endpackage
`default_nettype wire

FILE: sv/sql_transaction_keyword_classifier.sv
// top level of the sql transaction keyword classifier
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | in        | in_valid / in_ready  | char_byte, last_byte
//  out     | out       | out_valid / out_ready| keyword_code, is_transaction_control
//
// one byte item is taken per cycle while in_ready is high; the front classifies it in
// the same cycle and the back scans it from the two-entry queue once it is stored, so a
// statement's result is registered after its last byte is popped from the queue
// reset puts the scanner in the leading-whitespace phase with an empty word and no result
// a held result only stalls the back on a final byte; other bytes keep flowing
// the queue absorbs back-end stalls until both of its entries are full; then in_ready drops
`timescale 1ns / 1ps
`default_nettype none
module sql_transaction_keyword_classifier #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      keyword_code,
	output logic            is_transaction_control
);

	// classified byte from the front
	stkc_pkg::cls_item_t front_item;
	// head of the queue, towards the back
	stkc_pkg::cls_item_t q_item;
	logic                q_valid;
	logic                q_ready;

	// character class and case folding
	stkc_front u_front (
		.char_byte (char_byte),
		.last_byte (last_byte),
		.item      (front_item)
	);

	// decouples the front from stalls at the result register
	stkc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// comment skipping, word capture, keyword match and result register
	stkc_back #(
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.q_valid                (q_valid),
		.q_ready                (q_ready),
		.q_item                 (q_item),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.keyword_code           (keyword_code),
		.is_transaction_control (is_transaction_control)
	);

endmodule
`default_nettype wire

FILE: sv/stkc_front.sv
// front end: sorts each incoming byte into a character class and folds case
`timescale 1ns / 1ps
`default_nettype none
module stkc_front (
	input  wire logic [7:0]        char_byte,
	input  wire logic              last_byte,
	output stkc_pkg::cls_item_t    item
);

	logic is_upper;
	logic is_lower;

	assign is_upper = (char_byte >= stkc_pkg::CH_UC_A) && (char_byte <= stkc_pkg::CH_UC_Z);
	assign is_lower = (char_byte >= stkc_pkg::CH_LC_A) && (char_byte <= stkc_pkg::CH_LC_Z);

	always_comb begin
		item.last = last_byte;
		item.ch   = is_upper ? (char_byte | stkc_pkg::CASE_BIT) : char_byte;
		if (char_byte == stkc_pkg::CH_LF || char_byte == stkc_pkg::CH_CR) begin
			item.cls = stkc_pkg::CC_EOL;
		end else if (char_byte == stkc_pkg::CH_SPACE ||
				(char_byte >= stkc_pkg::CH_TAB && char_byte <= stkc_pkg::CH_CR)) begin
			item.cls = stkc_pkg::CC_WS;
		end else if (char_byte == stkc_pkg::CH_DASH) begin
			item.cls = stkc_pkg::CC_DASH;
		end else if (char_byte == stkc_pkg::CH_SLASH) begin
			item.cls = stkc_pkg::CC_SLASH;
		end else if (char_byte == stkc_pkg::CH_STAR) begin
			item.cls = stkc_pkg::CC_STAR;
		end else if (is_upper || is_lower) begin
			item.cls = stkc_pkg::CC_LETTER;
		end else begin
			item.cls = stkc_pkg::CC_OTHER;
		end
	end

endmodule
`default_nettype wire

FILE: sv/stkc_queue.sv
// two-entry queue of classified bytes between front and back
`timescale 1ns / 1ps
`default_nettype none
module stkc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire stkc_pkg::cls_item_t push_item,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output stkc_pkg::cls_item_t      pop_item
);

	stkc_pkg::cls_item_t entries_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/stkc_back.sv
// back end: scan state machine, letter store, keyword match and result register
`timescale 1ns / 1ps
`default_nettype none
module stkc_back #(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire stkc_pkg::cls_item_t q_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               keyword_code,
	output logic                     is_transaction_control
);

	localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);

	stkc_pkg::scan_phase_t phase_q;
	stkc_pkg::scan_phase_t phase_step;
	logic [7:0]            chars_q [MAX_KEYWORD_LEN];
	logic [LEN_W-1:0]      length_q;
	logic                  overflow_q;
	logic                  out_valid_q;
	stkc_pkg::kw_code_t    code_q;

	logic                  pop;
	logic                  take;
	logic                  store;
	logic                  overflow_set;
	logic [7:0]            eff_chars [MAX_KEYWORD_LEN];
	logic [LEN_W-1:0]      eff_len;
	logic                  eff_ovf;
	logic                  word_ok;
	logic [stkc_pkg::KW_COUNT-1:0] hit;
	stkc_pkg::kw_code_t    match_code;

	assign q_ready = !q_item.last || !out_valid_q || out_ready;
	assign pop     = q_valid && q_ready;

	// next state of the scanner
	always_comb begin
		phase_step = phase_q;
		unique case (phase_q)
			stkc_pkg::PH_SKIP: begin
				unique case (q_item.cls) inside
					stkc_pkg::CC_WS, stkc_pkg::CC_EOL: phase_step = stkc_pkg::PH_SKIP;
					stkc_pkg::CC_DASH:   phase_step = stkc_pkg::PH_DASH;
					stkc_pkg::CC_SLASH:  phase_step = stkc_pkg::PH_SLASH;
					stkc_pkg::CC_LETTER: phase_step = stkc_pkg::PH_WORD;
					default:             phase_step = stkc_pkg::PH_DONE;
				endcase
			end
			stkc_pkg::PH_DASH: begin
				phase_step = (q_item.cls == stkc_pkg::CC_DASH) ?
					stkc_pkg::PH_LINE : stkc_pkg::PH_DONE;
			end
			stkc_pkg::PH_LINE: begin
				if (q_item.cls == stkc_pkg::CC_EOL) begin
					phase_step = stkc_pkg::PH_SKIP;
				end
			end
			stkc_pkg::PH_SLASH: begin
				phase_step = (q_item.cls == stkc_pkg::CC_STAR) ?
					stkc_pkg::PH_BLOCK : stkc_pkg::PH_DONE;
			end
			stkc_pkg::PH_BLOCK: begin
				if (q_item.cls == stkc_pkg::CC_STAR) begin
					phase_step = stkc_pkg::PH_BLOCK_STAR;
				end
			end
			stkc_pkg::PH_BLOCK_STAR: begin
				if (q_item.cls == stkc_pkg::CC_SLASH) begin
					phase_step = stkc_pkg::PH_SKIP;
				end else if (q_item.cls != stkc_pkg::CC_STAR) begin
					phase_step = stkc_pkg::PH_BLOCK;
				end
			end
			stkc_pkg::PH_WORD: begin
				if (q_item.cls != stkc_pkg::CC_LETTER) begin
					phase_step = stkc_pkg::PH_DONE;
				end
			end
			stkc_pkg::PH_DONE: phase_step = stkc_pkg::PH_DONE;
			default:           phase_step = stkc_pkg::PH_DONE;
		endcase
	end

	// scanner outputs: letter capture
	always_comb begin
		take = 1'b0;
		unique case (phase_q) inside
			stkc_pkg::PH_SKIP, stkc_pkg::PH_WORD: take = (q_item.cls == stkc_pkg::CC_LETTER);
			default: take = 1'b0;
		endcase
		store        = take && (length_q < LEN_W'(MAX_KEYWORD_LEN));
		overflow_set = take && !store;
	end

	// word as it stands after this byte
	always_comb begin
		for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
			eff_chars[i] = (store && length_q[IDX_W-1:0] == IDX_W'(i)) ? q_item.ch : chars_q[i];
		end
		eff_len = length_q + LEN_W'(store);
		eff_ovf = overflow_q | overflow_set;
		word_ok = (phase_step == stkc_pkg::PH_WORD || phase_step == stkc_pkg::PH_DONE) &&
			(eff_len != '0) && !eff_ovf;
	end

	always_comb begin
		for (int k = 0; k < stkc_pkg::KW_COUNT; k++) begin
			hit[k] = (eff_len == LEN_W'(stkc_pkg::KW_LEN[k]));
			for (int i = 0; i < stkc_pkg::KW_TEXT_LEN; i++) begin
				if (i < int'(stkc_pkg::KW_LEN[k])) begin
					hit[k] = hit[k] && (eff_chars[i] ==
						stkc_pkg::KW_TEXT[k][(int'(stkc_pkg::KW_LEN[k]) - 1 - i) * 8 +: 8]);
				end
			end
		end
	end

	// lowest matching entry wins
	always_comb begin
		match_code = stkc_pkg::KW_NONE;
		if (word_ok) begin
			for (int k = stkc_pkg::KW_COUNT - 1; k >= 0; k--) begin
				if (hit[k]) begin
					match_code = stkc_pkg::kw_code_t'(3'(k + 1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && store) begin
			chars_q[length_q[IDX_W-1:0]] <= q_item.ch;
		end
		if (pop && q_item.last) begin
			code_q <= match_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= stkc_pkg::PH_SKIP;
			length_q    <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_item.last) begin
					phase_q    <= stkc_pkg::PH_SKIP;
					length_q   <= '0;
					overflow_q <= 1'b0;
				end else begin
					phase_q    <= phase_step;
					length_q   <= eff_len;
					overflow_q <= eff_ovf;
				end
			end
			if (pop && q_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid              = out_valid_q;
	assign keyword_code           = code_q;
	assign is_transaction_control = (code_q != stkc_pkg::KW_NONE);

endmodule
`default_nettype wire

FILE: sv/stkc_checker.sv
// port checker for the keyword classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sql_transaction_keyword_classifier_assert.svh"
module stkc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] char_byte,
	input wire logic       last_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] keyword_code,
	input wire logic       is_transaction_control
);

	// a waiting input item holds
	`STKC_ASSERT_PROP(a_in_hold, clk, arst_n, in_valid && !in_ready |=> in_valid && $stable(char_byte) && $stable(last_byte), "input item changed while waiting")

	// a stalled result holds
	`STKC_ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(keyword_code) && $stable(is_transaction_control), "result changed while stalled")

	// flag agrees with the code
	`STKC_ASSERT_PROP(a_flag_code, clk, arst_n, out_valid |-> (is_transaction_control == (keyword_code != 3'd0)), "flag disagrees with keyword code")

	// only the seven defined codes appear
	`STKC_ASSERT_PROP(a_code_range, clk, arst_n, out_valid |-> (keyword_code != 3'd7), "undefined keyword code")

	// no result on the first edge out of reset
	`STKC_ASSERT_ALWAYS(a_reset_quiet, clk, $rose(arst_n) |-> !out_valid, "result shown straight out of reset")

endmodule

bind sql_transaction_keyword_classifier stkc_checker u_stkc_checker (.*);
`default_nettype wire

FILE: dv/sql_transaction_keyword_classifier_checker.sv
// checker for the keyword classifier: predicts each statement's keyword and compares results
`timescale 1ns / 1ps
module sql_transaction_keyword_classifier_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       last_byte,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [2:0] keyword_code,
	input  wire logic       is_transaction_control,
	output int              mismatches,
	output int              results_due
);
	import stkc_pkg::*;

	localparam int WORD_MAX = 8;

	scan_phase_t scan_state = PH_SKIP;
	logic [63:0] word_bits = '0;
	int unsigned word_len = 0;
	logic        word_long = 1'b0;
	kw_code_t    due_keywords[$];
	kw_code_t    seen_kw;
	int          error_tally = 0;

	assign mismatches = error_tally;

	function automatic kw_code_t match_word(input logic [63:0] w, input int unsigned n);
		if (n == 5 && w == "begin") return KW_BEGIN;
		if (n == 5 && w == "start") return KW_START;
		if (n == 6 && w == "commit") return KW_COMMIT;
		if (n == 3 && w == "end") return KW_END;
		if (n == 8 && w == "rollback") return KW_ROLLBACK;
		if (n == 5 && w == "abort") return KW_ABORT;
		return KW_NONE;
	endfunction

	task automatic clear_scan();
		scan_state = PH_SKIP;
		word_bits  = '0;
		word_len   = 0;
		word_long  = 1'b0;
	endtask

	// letters fold to lower case; past the limit only the overflow mark is kept
	task automatic take_letter(input logic [7:0] ch);
		if (word_len < WORD_MAX) begin
			word_bits = {word_bits[55:0], ch | CASE_BIT};
			word_len++;
		end else begin
			word_long = 1'b1;
		end
	endtask

	// advance the scan by one byte and queue the keyword on the final one
	task automatic scan_byte(input logic [7:0] ch, input logic fin);
		logic     ws, letter;
		kw_code_t kw;
		ws     = ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
		letter = (ch >= CH_UC_A && ch <= CH_UC_Z) || (ch >= CH_LC_A && ch <= CH_LC_Z);
		case (scan_state)
		PH_SKIP: begin
			if (ws) begin
			end else if (ch == CH_DASH) begin
				scan_state = PH_DASH;
			end else if (ch == CH_SLASH) begin
				scan_state = PH_SLASH;
			end else if (letter) begin
				take_letter(ch);
				scan_state = PH_WORD;
			end else begin
				scan_state = PH_DONE;
			end
		end
		PH_DASH:  scan_state = (ch == CH_DASH) ? PH_LINE : PH_DONE;
		PH_LINE: begin
			if (ch == CH_LF || ch == CH_CR) scan_state = PH_SKIP;
		end
		PH_SLASH: scan_state = (ch == CH_STAR) ? PH_BLOCK : PH_DONE;
		PH_BLOCK: begin
			if (ch == CH_STAR) scan_state = PH_BLOCK_STAR;
		end
		PH_BLOCK_STAR: begin
			if (ch == CH_SLASH) scan_state = PH_SKIP;
			else if (ch != CH_STAR) scan_state = PH_BLOCK;
		end
		PH_WORD: begin
			if (letter) take_letter(ch);
			else scan_state = PH_DONE;
		end
		default: scan_state = PH_DONE;
		endcase
		if (fin) begin
			kw = KW_NONE;
			if ((scan_state == PH_WORD || scan_state == PH_DONE) && word_len != 0 && !word_long)
				kw = match_word(word_bits, word_len);
			due_keywords = {due_keywords, kw};
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			due_keywords.delete();
			results_due <= 0;
		end else begin
			if (in_valid && in_ready) scan_byte(char_byte, last_byte);
			if (out_valid && out_ready) begin
				if (due_keywords.size() == 0) begin
					$display("%0t: result with none due, got code %0d flag %0b", $time,
						keyword_code, is_transaction_control);
					error_tally++;
				end else begin
					seen_kw = due_keywords.pop_front();
					if (keyword_code !== seen_kw) begin
						$display("%0t: keyword_code expected %0d got %0d", $time, seen_kw,
							keyword_code);
						error_tally++;
					end
					if (is_transaction_control !== (seen_kw != KW_NONE)) begin
						$display("%0t: is_transaction_control expected %0b got %0b", $time,
							seen_kw != KW_NONE, is_transaction_control);
						error_tally++;
					end
				end
			end
			results_due <= due_keywords.size();
		end
	end
endmodule

FILE: dv/sql_transaction_keyword_classifier_tb.sv
// testbench top for the keyword classifier: statement stimulus, idling and verdict
`timescale 1ns / 1ps
module sql_transaction_keyword_classifier_tb;
	import stkc_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam int PHASE_BYTES = 590;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_byte = '0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] keyword_code;
	logic       is_transaction_control;
	int         mismatches;
	int         results_due;

	// idle chances in percent for each side, changed between phases
	int send_idle_pct = 24;
	int recv_idle_pct = 71;
	int bytes_sent = 0;
	int cycle_count = 0;
	int phase_end;

	// one statement, built byte by byte before it is sent
	logic [7:0] stmt_q[$];
	string kw_names[6] = '{"begin", "start", "commit", "end", "rollback", "abort"};

	sql_transaction_keyword_classifier uut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.char_byte              (char_byte),
		.last_byte              (last_byte),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.keyword_code           (keyword_code),
		.is_transaction_control (is_transaction_control)
	);

	sql_transaction_keyword_classifier_checker chk (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.char_byte              (char_byte),
		.last_byte              (last_byte),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.keyword_code           (keyword_code),
		.is_transaction_control (is_transaction_control),
		.mismatches             (mismatches),
		.results_due            (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls at random, one decision per cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog, independent of the stimulus thread
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// add one byte to the end of the statement
	task automatic append_byte(input logic [7:0] b);
		stmt_q = {stmt_q, b};
	endtask

	// send the queued statement; last_byte marks its final item
	task automatic send_stmt();
		for (int i = 0; i < stmt_q.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid  <= 1'b1;
			char_byte <= stmt_q[i];
			last_byte <= (i == stmt_q.size() - 1);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			bytes_sent++;
		end
	endtask

	task automatic send_text(input string s);
		stmt_q.delete();
		for (int i = 0; i < s.len(); i++) append_byte(s[i]);
		send_stmt();
	endtask

	// hold the sender off until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	// mostly well-formed statements: filler, then a word, then a tail;
	// the rest is noise, lone comment openers and unclosed comments
	task automatic build_statement();
		int         k;
		int         n;
		logic [7:0] b;
		string      w;
		stmt_q.delete();
		if ($urandom_range(99) < 18) begin
			case ($urandom_range(4))
			0: repeat ($urandom_range(6, 1)) append_byte(8'($urandom));
			1: begin
				append_byte(CH_DASH);
				repeat ($urandom_range(3)) append_byte(8'($urandom));
			end
			2: begin
				append_byte(CH_SLASH);
				repeat ($urandom_range(3)) append_byte(8'($urandom));
			end
			3: begin
				// block comment left open, letters inside
				append_byte(CH_SLASH);
				append_byte(CH_STAR);
				repeat ($urandom_range(5)) append_byte(CH_LC_A + 8'($urandom_range(25)));
			end
			default: begin
				// line comment running to the end
				append_byte(CH_DASH);
				append_byte(CH_DASH);
				repeat ($urandom_range(4)) append_byte(CH_LC_A + 8'($urandom_range(25)));
			end
			endcase
			return;
		end
		repeat ($urandom_range(3)) begin
			case ($urandom_range(3))
			0, 1: repeat ($urandom_range(3, 1)) begin
				k = $urandom_range(5);
				append_byte(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
			end
			2: begin
				append_byte(CH_DASH);
				append_byte(CH_DASH);
				repeat ($urandom_range(4)) begin
					b = 8'($urandom);
					if (b == CH_LF || b == CH_CR) b = CH_SPACE;
					append_byte(b);
				end
				append_byte($urandom_range(1) ? CH_LF : CH_CR);
			end
			default: begin
				append_byte(CH_SLASH);
				append_byte(CH_STAR);
				repeat ($urandom_range(5)) begin
					b = ($urandom_range(3) == 0) ? CH_STAR : 8'($urandom);
					if (b == CH_SLASH) b = CH_SPACE;
					append_byte(b);
				end
				repeat ($urandom_range(2, 1)) append_byte(CH_STAR);
				append_byte(CH_SLASH);
			end
			endcase
		end
		// now and then a statement of filler alone
		if ($urandom_range(19) == 0) begin
			if (stmt_q.size() == 0) append_byte(CH_SPACE);
			return;
		end
		k = $urandom_range(99);
		w = kw_names[$urandom_range(5)];
		n = w.len();
		if (k >= 65 && k < 75) n = $urandom_range(w.len() - 1, 1);
		if (k >= 75) begin
			// random word, up to four letters beyond the limit
			repeat ($urandom_range(12, 1)) begin
				b = CH_LC_A + 8'($urandom_range(25));
				append_byte($urandom_range(1) ? b : b & ~CASE_BIT);
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				b = w[i];
				append_byte($urandom_range(1) ? b : b & ~CASE_BIT);
			end
			// keyword with one letter too many
			if (k >= 55 && k < 65) append_byte(CH_UC_A + 8'($urandom_range(25)));
		end
		if ($urandom_range(2) != 0) begin
			b = 8'($urandom);
			if ((b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z)) b = ";";
			append_byte(b);
			repeat ($urandom_range(4)) append_byte(8'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every keyword, some in upper or mixed case, and each awkward opening
		send_text("end");
		send_text("\tBeGiN");
		send_text("--c\nstart");
		send_text("/**x*/COMMIT;");
		send_text("rollback");
		send_text(" abort x");
		send_text("rollbacks");
		send_text("-end");
		send_text("/a");
		send_text("1end");
		send_text("/*end");
		send_text("--end");
		send_text("\013\014\rend");
		stmt_q = '{8'hC1, 8'hFF};
		send_stmt();
		stmt_q = '{8'h00};
		send_stmt();
		drain();

		phase_end = bytes_sent + PHASE_BYTES;
		while (bytes_sent < phase_end) begin
			build_statement();
			send_stmt();
		end
		drain();

		send_idle_pct = 71;
		recv_idle_pct = 24;
		phase_end = bytes_sent + PHASE_BYTES;
		while (bytes_sent < phase_end) begin
			build_statement();
			send_stmt();
		end
		drain();

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase_end = bytes_sent + PHASE_BYTES;
		while (bytes_sent < phase_end) begin
			build_statement();
			send_stmt();
		end
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+sv
sv/stkc_pkg.sv
sv/stkc_front.sv
sv/stkc_queue.sv
sv/stkc_back.sv
sv/sql_transaction_keyword_classifier.sv
sv/stkc_checker.sv
dv/sql_transaction_keyword_classifier_checker.sv
dv/sql_transaction_keyword_classifier_tb.sv
